/* sv/biq_pkg.sv */
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants for the IQ biquad low-pass filter.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int DATA_W   = 16;   // sample and output width
  localparam int COEF_W   = 16;   // Q2.14 coefficient width
  localparam int YH_W     = 26;   // output history, 8 fraction bits
  localparam int ACC_W    = 45;   // accumulator, 22 fraction bits
  localparam int FRAC_SH  = 14;   // coefficient fraction bits
  localparam int YFRAC_SH = 8;    // history fraction bits
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // reset coefficients: Bessel, Fc = 0.25 fs
  localparam logic signed [COEF_W-1:0] RST_B0 = 16'sd4413;
  localparam logic signed [COEF_W-1:0] RST_B1 = 16'sd8827;
  localparam logic signed [COEF_W-1:0] RST_B2 = 16'sd4413;
  localparam logic signed [COEF_W-1:0] RST_A1 = 16'sd93;
  localparam logic signed [COEF_W-1:0] RST_A2 = 16'sd1176;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

endpackage

/* sv/biq_chan.sv */
// ----------------------------------------------------------------------------
// biq_chan
// One channel of the direct form I biquad: history registers plus the
// multiply-accumulate, truncation and saturation for one sample.
// ----------------------------------------------------------------------------
module biq_chan (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic signed [biq_pkg::DATA_W-1:0]     x,
  input  biq_pkg::coef_t                        coef,
  output logic signed [biq_pkg::DATA_W-1:0]     y
);
  import biq_pkg::*;

  localparam logic signed [ACC_W-1:0] YH_MAX_A = ACC_W'((2**(YH_W-1)) - 1);
  localparam logic signed [ACC_W-1:0] YH_MIN_A = -YH_MAX_A - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ACC_RND  = ACC_W'((2**FRAC_SH) - 1);
  localparam logic signed [YH_W:0]    Y_RND    = (YH_W+1)'((2**YFRAC_SH) - 1);
  localparam logic signed [YH_W:0]    O_MAX    = (YH_W+1)'((2**(DATA_W-1)) - 1);
  localparam logic signed [YH_W:0]    O_MIN    = -O_MAX - (YH_W+1)'(1);

  logic signed [DATA_W-1:0] x1_r, x2_r;
  logic signed [YH_W-1:0]   y1_r, y2_r;

  logic signed [2*DATA_W-1:0]      p_b0, p_b1, p_b2;
  logic signed [COEF_W+YH_W-1:0]   p_a1, p_a2;
  logic signed [2*DATA_W+1:0]      ff;
  logic signed [ACC_W-1:0]         acc, acc_adj, acc_q;
  logic signed [YH_W-1:0]          ynew;
  logic signed [YH_W:0]            y_adj, y_q;

  always_comb begin
    p_b0 = coef.b0 * x;
    p_b1 = coef.b1 * x1_r;
    p_b2 = coef.b2 * x2_r;
    p_a1 = coef.a1 * y1_r;
    p_a2 = coef.a2 * y2_r;
    ff   = (2*DATA_W+2)'(p_b0) + (2*DATA_W+2)'(p_b1) + (2*DATA_W+2)'(p_b2);
    acc  = (ACC_W'(ff) <<< YFRAC_SH) - ACC_W'(p_a1) - ACC_W'(p_a2);
    // divide by 2^14 toward zero
    acc_adj = acc[ACC_W-1] ? (acc + ACC_RND) : acc;
    acc_q   = acc_adj >>> FRAC_SH;
    priority if (acc_q > YH_MAX_A) begin
      ynew = YH_MAX_A[YH_W-1:0];
    end else if (acc_q < YH_MIN_A) begin
      ynew = YH_MIN_A[YH_W-1:0];
    end else begin
      ynew = acc_q[YH_W-1:0];
    end
    // drop the 8 history fraction bits toward zero, then clip to int16
    y_adj = ynew[YH_W-1] ? ((YH_W+1)'(ynew) + Y_RND) : (YH_W+1)'(ynew);
    y_q   = y_adj >>> YFRAC_SH;
    priority if (y_q > O_MAX) begin
      y = O_MAX[DATA_W-1:0];
    end else if (y_q < O_MIN) begin
      y = O_MIN[DATA_W-1:0];
    end else begin
      y = y_q[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (adv) begin
      x2_r <= x1_r;
      x1_r <= x;
      y2_r <= y1_r;
      y1_r <= ynew;
    end
  end

  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (x2_r == $past(x1_r)) && (y2_r == $past(y1_r)))
    else $error("biq_chan: history did not shift on advance");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(y1_r) && $stable(x1_r))
    else $error("biq_chan: history changed without advance");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> ((y1_r >= 0) == ($past(y) >= 0)) || ($past(y) == 0))
    else $error("biq_chan: output sign disagrees with stored history");

endmodule

/* sv/iq_biquad_lowpass.sv */
// ----------------------------------------------------------------------------
// iq_biquad_lowpass
// Direct form I biquad low-pass on the I and Q samples of a complex stream,
// shared Q2.14 coefficients, last flag passed through.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, in_sample_i/q, in_last.. | sink
//  out     | out_valid, out_stall, out_i/q, out_last_out  | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | sink
//
//  One word per clock sustained while the output is not stalled; each word
//  passes through the input register and then the result register.
//  The per-sample feedback through the previous output sets the critical
//  path: five multiplies, a sum, truncate and clip, all combinational.
//  Synchronous reset loads the default coefficients and clears all history.
//  A stalled output holds the result; input takes a word while the input
//  register is empty or moving into the result register.
// ----------------------------------------------------------------------------
module iq_biquad_lowpass (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [biq_pkg::DATA_W-1:0]        in_sample_i,
  input  logic signed [biq_pkg::DATA_W-1:0]        in_sample_q,
  input  logic                                     in_last_in_block,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [biq_pkg::DATA_W-1:0]        out_i,
  output logic signed [biq_pkg::DATA_W-1:0]        out_q,
  output logic                                     out_last_out,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [biq_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]               cfg_data
);
  import biq_pkg::*;

  coef_t coef_r;

  logic                     in_valid_r;
  logic signed [DATA_W-1:0] x_i_r, x_q_r;
  logic                     last_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_i_r, out_q_r;
  logic                     out_last_r;

  logic                     out_ready;
  logic                     adv;
  logic                     in_take;
  logic signed [DATA_W-1:0] y_i, y_q;

  assign out_ready = !out_valid_r || !out_stall;
  assign adv       = in_valid_r && out_ready;
  assign in_stall  = in_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // coefficient registers; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= RST_B0;
      coef_r.b1 <= RST_B1;
      coef_r.b2 <= RST_B2;
      coef_r.a1 <= RST_A1;
      coef_r.a2 <= RST_A2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_B0:  coef_r.b0 <= cfg_data;
        REG_B1:  coef_r.b1 <= cfg_data;
        REG_B2:  coef_r.b2 <= cfg_data;
        REG_A1:  coef_r.a1 <= cfg_data;
        REG_A2:  coef_r.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || adv) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_i_r  <= in_sample_i;
      x_q_r  <= in_sample_q;
      last_r <= in_last_in_block;
    end
  end

  biq_chan u_chan_i (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .x     (x_i_r),
    .coef  (coef_r),
    .y     (y_i)
  );

  biq_chan u_chan_q (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .x     (x_q_r),
    .coef  (coef_r),
    .y     (y_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_i_r    <= y_i;
      out_q_r    <= y_q;
      out_last_r <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_i        = out_i_r;
  assign out_q        = out_q_r;
  assign out_last_out = out_last_r;

  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_valid_r)
    else $error("iq_biquad_lowpass: accepted word missing from input register");

  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && (out_last_r == $past(last_r)))
    else $error("iq_biquad_lowpass: advanced word missing from result register");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !in_valid_r) |=> !out_valid_r)
    else $error("iq_biquad_lowpass: result repeated after being taken");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> in_valid_r && $stable(x_i_r) && $stable(x_q_r))
    else $error("iq_biquad_lowpass: stalled input register changed");

endmodule
